### src/mvm_pkg.sv
package mvm_pkg;

	localparam int MAX_SIZE_DEF = 64;
	localparam int COL_LIMIT = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MATRIX = 1'b1;

	localparam logic [6:0] SIZE_RESET = 7'd64;

	localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic req_type;
		logic [5:0] column;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic [5:0] row;
		logic signed [63:0] result;
		logic saturated;
	} rsp_item_t;

	typedef struct packed {
		logic is_mac;
		logic last;
		logic [5:0] column;
		logic signed [31:0] value;
	} queue_entry_t;

endpackage

### src/mvm_front.sv
module mvm_front
	import mvm_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic size_we,
	input logic [6:0] size_wdata,
	input logic req_valid,
	output logic req_stall,
	input req_item_t req,
	input logic queue_full,
	output logic push,
	output queue_entry_t push_entry
);

	localparam int STORE_DEPTH = (MAX_SIZE < COL_LIMIT) ? MAX_SIZE : COL_LIMIT;
	localparam logic [6:0] SIZE_LIMIT = 7'(STORE_DEPTH);

	logic [6:0] size_q;
	logic [6:0] active_size;
	logic [6:0] column_ext;
	logic accepted;
	logic keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (size_we) begin
			size_q <= size_wdata;
		end
	end

	always_comb begin
		active_size = size_q;
		if (active_size == 7'd0) begin
			active_size = 7'd1;
		end
		if (active_size > SIZE_LIMIT) begin
			active_size = SIZE_LIMIT;
		end
	end

	assign column_ext = {1'b0, req.column};
	assign req_stall = queue_full;
	assign accepted = req_valid && !queue_full;

	// Loads beyond the store and matrix elements beyond the active size are dropped here.
	always_comb begin
		case (req.req_type)
			REQ_LOAD: keep = column_ext < SIZE_LIMIT;
			REQ_MATRIX: keep = column_ext < active_size;
			default: keep = 1'b0;
		endcase
	end

	assign push = accepted && keep;
	assign push_entry.is_mac = (req.req_type == REQ_MATRIX);
	assign push_entry.last = (column_ext == (active_size - 7'd1));
	assign push_entry.column = req.column;
	assign push_entry.value = req.value;

endmodule

### src/mvm_queue.sv
module mvm_queue
	import mvm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input queue_entry_t push_entry,
	output logic full,
	output logic head_valid,
	output queue_entry_t head_entry,
	input logic pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	queue_entry_t slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_pop;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### src/mvm_back.sv
module mvm_back
	import mvm_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input queue_entry_t head_entry,
	output logic pop,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_item_t rsp
);

	localparam int STORE_DEPTH = (MAX_SIZE < COL_LIMIT) ? MAX_SIZE : COL_LIMIT;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [31:0] vector_mem [STORE_DEPTH];
	logic [AW-1:0] addr;
	logic adv;

	logic v_s1;
	logic last_s1;
	logic [5:0] col_s1;
	logic signed [31:0] value_s1;
	logic signed [31:0] vec_s1;

	logic v_s2;
	logic last_s2;
	logic [5:0] col_s2;
	logic signed [63:0] prod_s2;

	logic [63:0] acc_q;
	logic clip_q;
	logic [5:0] row_q;
	logic rsp_valid_q;
	rsp_item_t rsp_q;

	logic [63:0] sum;
	logic [63:0] sum_sat;
	logic ovf;

	// The whole back end moves together whenever the result register can take a transfer.
	assign adv = !rsp_valid_q || !rsp_stall;
	assign pop = adv && head_valid;
	assign addr = head_entry.column[AW-1:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_entry.is_mac) begin
				vec_s1 <= vector_mem[addr];
			end else begin
				vector_mem[addr] <= head_entry.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= head_entry.last;
			col_s1 <= head_entry.column;
			value_s1 <= head_entry.value;
			last_s2 <= last_s1;
			col_s2 <= col_s1;
			prod_s2 <= value_s1 * vec_s1;
		end
	end

	assign sum = acc_q + prod_s2;
	assign ovf = (acc_q[63] == prod_s2[63]) && (sum[63] != acc_q[63]);
	assign sum_sat = ovf ? (acc_q[63] ? ACC_MIN : ACC_MAX) : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			acc_q <= '0;
			clip_q <= 1'b0;
			row_q <= '0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop && head_entry.is_mac;
			v_s2 <= v_s1;
			rsp_valid_q <= v_s2 && last_s2;
			if (v_s2) begin
				if (last_s2) begin
					acc_q <= '0;
					clip_q <= 1'b0;
					row_q <= (row_q >= col_s2) ? 6'd0 : row_q + 6'd1;
				end else begin
					acc_q <= sum_sat;
					clip_q <= clip_q || ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && last_s2) begin
			rsp_q.row <= row_q;
			rsp_q.result <= sum_sat;
			rsp_q.saturated <= clip_q || ovf;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && last_s2) |=> (acc_q == '0 && !clip_q))
		else $error("Accumulator not cleared after a row closed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(v_s2 && last_s2))
		else $error("Result appeared without a closing element.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(acc_q) && $stable(row_q) && $stable(clip_q)))
		else $error("Row state changed while the back end was held.");

endmodule

### src/matrix_vector_multiply_unit.sv
// Streaming matrix-vector multiplier in Q16.16 with a saturating Q32.32 row
// accumulator. A request transfer, vector load or matrix element, is taken
// while earlier ones are still in flight, unless the queue is full. A four
// entry queue separates request classification from the read, multiply and
// accumulate pipeline; after a row's last element is taken, its sum passes
// the read stage, the product register and the result register, and the
// pipeline holds only while a result waits under stall.
module matrix_vector_multiply_unit
	import mvm_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic size_we,
	input logic [6:0] size_wdata,
	input logic req_valid,
	output logic req_stall,
	input req_item_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_item_t rsp
);

	logic queue_full;
	logic push;
	queue_entry_t push_entry;
	logic head_valid;
	queue_entry_t head_entry;
	logic pop;

	mvm_front #(
		.MAX_SIZE(MAX_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.size_we(size_we),
		.size_wdata(size_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.queue_full(queue_full),
		.push(push),
		.push_entry(push_entry)
	);

	mvm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(queue_full),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop(pop)
	);

	mvm_back #(
		.MAX_SIZE(MAX_SIZE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
